FILE: rtl/core/pawf_pkg.sv
// ----------------------------------------------------------------------------
// PID anti-windup friction package
// Widths, types and register indexes shared by the controller core and its
// checker.
// ----------------------------------------------------------------------------
package pawf_pkg;

	// Fixed-point format of all data words.
	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int MAG_W  = DATA_W - 1;

	// Product, scaled term and term sum widths.
	localparam int PROD_W = 2 * DATA_W + 1;
	localparam int TERM_W = PROD_W - FRAC_W;
	localparam int SUM_W  = TERM_W + 1;

	// Setpoint magnitude times ten.
	localparam int SPX_W  = DATA_W + 4;

	localparam int CFG_IDX_W = 3;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t REG_GAIN_P     = cfg_idx_t'(0);
	localparam cfg_idx_t REG_GAIN_I     = cfg_idx_t'(1);
	localparam cfg_idx_t REG_GAIN_D     = cfg_idx_t'(2);
	localparam cfg_idx_t REG_OUT_MIN    = cfg_idx_t'(3);
	localparam cfg_idx_t REG_OUT_MAX    = cfg_idx_t'(4);
	localparam cfg_idx_t REG_INT_THRESH = cfg_idx_t'(5);
	localparam cfg_idx_t REG_INT_LIMIT  = cfg_idx_t'(6);
	localparam cfg_idx_t REG_FRICTION   = cfg_idx_t'(7);

	// Input command codes.
	localparam logic CMD_MEASURE  = 1'b0;
	localparam logic CMD_SETPOINT = 1'b1;

	// One tenth threshold: |setpoint| * 10 is compared against 1.0.
	localparam logic [SPX_W-1:0] ONE_X = SPX_W'(64'd1 << FRAC_W);

endpackage

FILE: rtl/core/pid_anti_windup_friction_core.sv
// ----------------------------------------------------------------------------
// PID regulator with conditional integration and friction floor
// Signed fixed-point PID with integral clamp, friction floor and output clamp.
// ----------------------------------------------------------------------------
// Usage:
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes the gains, clamps, integration threshold, integral limit and
// friction floor. It is always ready and must only be used while idle.
// The input channel (in_valid, in_stall, cmd, value) takes one word per
// cycle while in_stall is low. A setpoint word (cmd high) updates the
// setpoint and yields no result. A measurement word yields one drive word
// on the output channel (out_valid, out_stall, drive). Words pass the
// input register, stages 2 to 4 and the output register at one word per
// cycle while out_stall is low. The integral and error state is updated in
// the first stage, so consecutive words see each other without bubbles.
// The three multipliers sit in their own stage, the term sum in the next,
// and the friction floor and output clamp in the output register stage.
// When the receiver stalls, the output word holds and the stages behind it
// keep filling until every stage is occupied, then in_stall rises.
// Reset zeroes the gains, configuration and state, and empties the pipe.
// ----------------------------------------------------------------------------
module pid_anti_windup_friction_core import pawf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  cfg_idx_t cfg_index,
	input  data_t    cfg_data,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     cmd,
	input  data_t    value,
	output logic     out_valid,
	input  logic     out_stall,
	output data_t    drive
);

	// Configuration registers.
	data_t gain_p_q, gain_i_q, gain_d_q, out_min_q, out_max_q;
	mag_t  thresh_q, limit_q, friction_q;

	// Controller state.
	data_t sp_q, sum_q, prev_q;
	logic  sp_big_q;

	// Pipeline registers.
	logic  v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic  cmd_s1;
	data_t value_s1;
	data_t err_s2, sum_s2;
	logic signed [DATA_W:0] diff_s2;
	logic  fric_s2, fric_s3, fric_s4;
	logic signed [PROD_W-1:0] prod_p_s3, prod_i_s3, prod_d_s3;
	logic signed [SUM_W-1:0]  y_s4;
	data_t drive_q;

	// Stage ready chain.
	logic rdy_out, rdy_s4, rdy_s3, rdy_s2, rdy_s1;

	// Stage 1 combinational signals.
	logic signed [DATA_W:0] sp_diff, acc, lim_pos, lim_neg, acc_clamp, dterm;
	data_t                  err, sum_next;
	logic [DATA_W-1:0]      err_mag, val_mag;
	logic [SPX_W-1:0]       val_x10;
	logic                   integ_en;

	// Output stage combinational signals.
	logic signed [SUM_W-1:0] y_abs, fr_pos, y_fric, y_max, y_min, y_clamp;
	logic                    fric_hit;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q   <= '0;
			gain_i_q   <= '0;
			gain_d_q   <= '0;
			out_min_q  <= '0;
			out_max_q  <= '0;
			thresh_q   <= '0;
			limit_q    <= '0;
			friction_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_P:     gain_p_q   <= cfg_data;
				REG_GAIN_I:     gain_i_q   <= cfg_data;
				REG_GAIN_D:     gain_d_q   <= cfg_data;
				REG_OUT_MIN:    out_min_q  <= cfg_data;
				REG_OUT_MAX:    out_max_q  <= cfg_data;
				REG_INT_THRESH: thresh_q   <= cfg_data[MAG_W-1:0];
				REG_INT_LIMIT:  limit_q    <= cfg_data[MAG_W-1:0];
				REG_FRICTION:   friction_q <= cfg_data[MAG_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage can load when it is empty or its word moves on.
	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy_s4   = !v_s4 || rdy_out;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1 && (cmd_s1 == CMD_MEASURE);
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_out) out_valid_q <= v_s4;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			cmd_s1   <= cmd;
			value_s1 <= value;
		end
	end

	// Error, saturated to the data width.
	always_comb begin
		sp_diff = {sp_q[DATA_W-1], sp_q} - {value_s1[DATA_W-1], value_s1};
		if (sp_diff[DATA_W] != sp_diff[DATA_W-1]) begin
			err = sp_diff[DATA_W] ? {1'b1, {MAG_W{1'b0}}} : {1'b0, {MAG_W{1'b1}}};
		end else begin
			err = sp_diff[DATA_W-1:0];
		end
		err_mag  = err[DATA_W-1] ? (~err + 1'b1) : err;
		integ_en = err_mag < {1'b0, thresh_q};
	end

	// Integral update with symmetric clamp, zeroed outside the threshold, and the difference term.
	always_comb begin
		acc     = {sum_q[DATA_W-1], sum_q} + {err[DATA_W-1], err};
		lim_pos = {2'b00, limit_q};
		lim_neg = -lim_pos;
		if (acc > lim_pos) begin
			acc_clamp = lim_pos;
		end else if (acc < lim_neg) begin
			acc_clamp = lim_neg;
		end else begin
			acc_clamp = acc;
		end
		sum_next = integ_en ? acc_clamp[DATA_W-1:0] : '0;
		dterm    = {prev_q[DATA_W-1], prev_q} - {err[DATA_W-1], err};
	end

	// Ten times the magnitude of an incoming setpoint.
	always_comb begin
		val_mag = value_s1[DATA_W-1] ? (~value_s1 + 1'b1) : value_s1;
		val_x10 = {1'b0, val_mag, 3'b000} + {3'b000, val_mag, 1'b0};
	end

	// Controller state, updated as a word leaves the first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			sp_big_q <= 1'b0;
			sum_q    <= '0;
			prev_q   <= '0;
		end else if (v_s1 && rdy_s2) begin
			if (cmd_s1 == CMD_SETPOINT) begin
				sp_q     <= value_s1;
				sp_big_q <= val_x10 > ONE_X;
				if (val_x10 < ONE_X) sum_q <= '0;
			end else begin
				sum_q  <= sum_next;
				prev_q <= err;
			end
		end
	end

	// Stage 2: operands for the multipliers.
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			err_s2  <= err;
			sum_s2  <= sum_next;
			diff_s2 <= dterm;
			fric_s2 <= sp_big_q;
		end
	end

	// Stage 3: the three gain products.
	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			prod_p_s3 <= PROD_W'(gain_p_q) * PROD_W'(err_s2);
			prod_i_s3 <= PROD_W'(gain_i_q) * PROD_W'(sum_s2);
			prod_d_s3 <= PROD_W'(gain_d_q) * PROD_W'(diff_s2);
			fric_s3   <= fric_s2;
		end
	end

	// Stage 4: scale each product down, rounding toward minus infinity, and sum.
	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			y_s4 <= SUM_W'($signed(prod_p_s3[PROD_W-1:FRAC_W]))
				+ SUM_W'($signed(prod_i_s3[PROD_W-1:FRAC_W]))
				+ SUM_W'($signed(prod_d_s3[PROD_W-1:FRAC_W]));
			fric_s4 <= fric_s3;
		end
	end

	// Friction floor, then clamp to the upper and then the lower limit.
	always_comb begin
		y_abs    = y_s4[SUM_W-1] ? -y_s4 : y_s4;
		fr_pos   = SUM_W'({1'b0, friction_q});
		fric_hit = fric_s4 && (y_abs < fr_pos);
		if (fric_hit) begin
			y_fric = (y_s4 > 0) ? fr_pos : -fr_pos;
		end else begin
			y_fric = y_s4;
		end
		y_max   = SUM_W'(out_max_q);
		y_min   = SUM_W'(out_min_q);
		y_clamp = (y_fric > y_max) ? y_max : y_fric;
		if (y_clamp < y_min) y_clamp = y_min;
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (v_s4 && rdy_out) begin
			drive_q <= y_clamp[DATA_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule

FILE: rtl/core/pawf_checker.sv
// ----------------------------------------------------------------------------
// PID anti-windup friction port checker
// Watches the top-level ports of the controller core over time.
// ----------------------------------------------------------------------------
module pawf_checker import pawf_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  cfg_valid,
	input logic  cfg_ready,
	input logic  in_stall,
	input logic  out_valid,
	input logic  out_stall,
	input data_t drive
);

	// A stalled output word stays valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// A stalled output word keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(drive))
		else $error("drive changed while stalled");

	// With an empty output register the pipe is never backed up.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	// Configuration writes are never held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind pid_anti_windup_friction_core pawf_checker u_pawf_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// PID anti-windup friction core testbench
// Feeds setpoint and measurement words through the valid/stall input channel
// under several register settings and idling patterns, predicts every drive
// word with an independent fixed-point model of the regulator, and compares
// each accepted drive word against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import pawf_pkg::*;

	// Run shape.
	localparam int RANDOM_PHASES    = 8;
	localparam int WORDS_PER_PHASE  = 200;
	localparam int LATENCY_SETTLE   = 8;
	localparam int MAX_REPORTS      = 60;
	localparam int RUN_LIMIT        = 2000000;

	// Fixed-point landmarks.
	localparam longint UNIT     = longint'(1) << FRAC_W;
	localparam longint DMAX_L   = (longint'(1) << (DATA_W - 1)) - 1;
	localparam longint DMIN_L   = -DMAX_L - 1;
	localparam longint TERM_CAP = longint'(1) << 61;
	localparam data_t  DATA_MAX = {1'b0, {MAG_W{1'b1}}};
	localparam data_t  DATA_MIN = {1'b1, {MAG_W{1'b0}}};
	localparam mag_t   MAG_MAX  = {MAG_W{1'b1}};

	typedef struct {
		logic  cmd;
		data_t value;
	} word_t;

	typedef struct {
		data_t gain_p;
		data_t gain_i;
		data_t gain_d;
		data_t out_min;
		data_t out_max;
		mag_t  thresh;
		mag_t  limit;
		mag_t  friction;
	} pid_cfg_t;

	typedef enum {SET_MODERATE, SET_EXTREME_HIGH, SET_EXTREME_LOW, SET_WIDE} settings_style_t;
	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	settings_style_t phase_plan [RANDOM_PHASES] = '{SET_MODERATE, SET_EXTREME_HIGH,
		SET_MODERATE, SET_WIDE, SET_MODERATE, SET_EXTREME_LOW, SET_MODERATE, SET_MODERATE};

	// Block ports.
	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	cfg_idx_t cfg_index = REG_GAIN_P;
	data_t    cfg_data  = '0;
	logic     in_valid  = 1'b0;
	logic     in_stall;
	logic     cmd       = CMD_MEASURE;
	data_t    value     = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	data_t    drive;

	// Stimulus and expectation stores.
	word_t pending_words [$];
	data_t drive_expected [$];
	int    words_loaded   = 0;
	int    words_accepted = 0;
	int    mismatches     = 0;
	int    send_idle_pct  = 0;
	int    stall_pct      = 0;
	logic  in_taken       = 1'b0;
	longint gen_setpoint  = 0;

	// Regulator state and register copies kept by the predictor.
	longint sp_now = 0, isum = 0, perr = 0;
	longint kp = 0, ki = 0, kd = 0, lo_clamp = 0, hi_clamp = 0;
	longint thresh = 0, ilimit = 0, fric = 0;

	pid_anti_windup_friction_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive)
	);

	// Clock with a period of 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic longint mag_of(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Fixed-point product, rounded toward minus infinity and capped at +-2^61.
	function automatic longint scaled_product(longint a, longint b);
		logic signed [127:0] wa, wb, p;
		wa = a;
		wb = b;
		p = (wa * wb) >>> FRAC_W;
		if (p > TERM_CAP) return TERM_CAP;
		if (p < -TERM_CAP) return -TERM_CAP;
		return longint'(p);
	endfunction

	// Advances the regulator by one accepted word and, for a measurement, queues its drive word.
	function automatic void predict_drive(logic c, data_t v);
		longint e, diff, y;
		if (c == CMD_SETPOINT) begin
			sp_now = v;
			// A setpoint below one tenth restarts the integral.
			if (mag_of(sp_now) * 10 < UNIT) isum = 0;
			return;
		end
		e = clip(sp_now - longint'(v), DMIN_L, DMAX_L);
		// Integrate only inside the threshold; a large error drops the sum.
		if (mag_of(e) < thresh) begin
			isum = clip(isum + e, -ilimit, ilimit);
		end else begin
			isum = 0;
		end
		diff = perr - e;
		perr = e;
		y = scaled_product(kp, e) + scaled_product(ki, isum) + scaled_product(kd, diff);
		// Friction floor; a zero drive is pushed to the negative side.
		if (mag_of(sp_now) * 10 > UNIT && mag_of(y) < fric) begin
			y = (y > 0) ? fric : -fric;
		end
		if (y > hi_clamp) y = hi_clamp;
		if (y < lo_clamp) y = lo_clamp;
		y = clip(y, DMIN_L, DMAX_L);
		drive_expected.push_back(data_t'(y));
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		// Keep the log short when something goes badly wrong.
		if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
	endtask

	task automatic load_word(logic c, data_t v);
		word_t w;
		w.cmd = c;
		w.value = v;
		pending_words.push_back(w);
		words_loaded++;
	endtask

	// One register write; the predictor copy changes at the handshake.
	task automatic write_reg(cfg_idx_t idx, data_t data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAIN_P: kp = data;
			REG_GAIN_I: ki = data;
			REG_GAIN_D: kd = data;
			REG_OUT_MIN: lo_clamp = data;
			REG_OUT_MAX: hi_clamp = data;
			REG_INT_THRESH: thresh = longint'(mag_t'(data));
			REG_INT_LIMIT: ilimit = longint'(mag_t'(data));
			REG_FRICTION: fric = longint'(mag_t'(data));
			default: ;
		endcase
	endtask

	task automatic apply_settings(pid_cfg_t s);
		write_reg(REG_GAIN_P, s.gain_p);
		write_reg(REG_GAIN_I, s.gain_i);
		write_reg(REG_GAIN_D, s.gain_d);
		write_reg(REG_OUT_MIN, s.out_min);
		write_reg(REG_OUT_MAX, s.out_max);
		write_reg(REG_INT_THRESH, data_t'(s.thresh));
		write_reg(REG_INT_LIMIT, data_t'(s.limit));
		write_reg(REG_FRICTION, data_t'(s.friction));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic pid_cfg_t pick_settings(settings_style_t style);
		pid_cfg_t s;
		data_t t;
		// Moderate gains and clamps keep the drive away from the rails.
		s.gain_p = $signed($urandom) >>> $urandom_range(31, 12);
		s.gain_i = $signed($urandom) >>> $urandom_range(31, 12);
		s.gain_d = $signed($urandom) >>> $urandom_range(31, 12);
		s.out_max = data_t'($urandom >> $urandom_range(1, 14));
		s.out_min = -data_t'($urandom >> $urandom_range(1, 14));
		s.thresh = mag_t'($urandom >> $urandom_range(1, 14));
		s.limit = mag_t'($urandom >> $urandom_range(1, 12));
		s.friction = mag_t'($urandom >> $urandom_range(8, 20));
		if ($urandom_range(7) == 0) begin
			t = s.out_min;
			s.out_min = s.out_max;
			s.out_max = t;
		end
		case (style)
			SET_EXTREME_HIGH: begin
				s.gain_p = $urandom_range(1) ? DATA_MAX : DATA_MIN;
				s.gain_i = $urandom_range(1) ? DATA_MAX : DATA_MIN;
				s.gain_d = $urandom_range(1) ? DATA_MAX : DATA_MIN;
				s.out_min = DATA_MIN;
				s.out_max = DATA_MAX;
				s.thresh = MAG_MAX;
				s.limit = MAG_MAX;
				s.friction = MAG_MAX;
			end
			SET_EXTREME_LOW: begin
				s.out_min = DATA_MIN;
				s.out_max = DATA_MAX;
				s.thresh = '0;
				s.limit = '0;
				s.friction = '0;
			end
			SET_WIDE: begin
				s.gain_p = $urandom;
				s.gain_i = $urandom;
				s.gain_d = $urandom;
				s.out_min = $urandom;
				s.out_max = $urandom;
				s.thresh = mag_t'($urandom);
				s.limit = mag_t'($urandom);
				s.friction = mag_t'($urandom);
			end
			default: ;
		endcase
		return s;
	endfunction

	// Mostly measurements near the setpoint so that integration takes place.
	function automatic word_t random_word();
		word_t w;
		int r;
		r = $urandom_range(99);
		w.cmd = CMD_MEASURE;
		if (r < 8) begin
			w.cmd = CMD_SETPOINT;
			case ($urandom_range(3))
				0: w.value = data_t'(longint'($urandom_range(13106)) - 6553);
				1: w.value = data_t'($urandom_range(1) ? 6553 : 6554)
					* ($urandom_range(1) ? 1 : -1);
				2: w.value = $signed($urandom) >>> $urandom_range(31, 8);
				default: w.value = $urandom;
			endcase
			gen_setpoint = w.value;
		end else if (r < 16) begin
			w.value = $urandom;
		end else if (r < 20) begin
			case ($urandom_range(2))
				0: w.value = DATA_MAX;
				1: w.value = DATA_MIN;
				default: w.value = '0;
			endcase
		end else begin
			w.value = data_t'(clip(gen_setpoint
				+ longint'($signed($urandom) >>> $urandom_range(31, 6)), DMIN_L, DMAX_L));
		end
		return w;
	endfunction

	task automatic set_idling(idle_mode_t m);
		case (m)
			IDLE_SENDER: begin
				send_idle_pct = 80;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				stall_pct = 80;
			end
			IDLE_BOTH: begin
				send_idle_pct = 38;
				stall_pct = 38;
			end
			default: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// Holds off until every loaded word is taken and every drive word is back.
	task automatic wait_drained();
		while (words_accepted != words_loaded || drive_expected.size() != 0) @(negedge clk);
	endtask

	// Input driver: a new word goes out at the falling edge once the last one was taken.
	always @(negedge clk) begin
		word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				cmd <= w.cmd;
				value <= w.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Monitor: check drive words, then feed accepted input words to the predictor.
	always @(posedge clk) begin
		data_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (drive_expected.size() == 0) begin
					report_mismatch($sformatf("drive word %h with none expected", drive));
				end else begin
					want = drive_expected.pop_front();
					if (drive !== want) begin
						report_mismatch($sformatf("drive %h, expected %h", drive, want));
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_drive(cmd, value);
				words_accepted++;
			end
		end
		in_taken <= arst_n && in_valid && !in_stall;
	end

	// Stimulus sequence.
	initial begin
		pid_cfg_t s;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Reset values: all gains and clamps are zero.
		@(posedge clk);
		load_word(CMD_MEASURE, DATA_MAX);
		load_word(CMD_SETPOINT, data_t'(UNIT));
		load_word(CMD_MEASURE, '0);
		wait_drained();
		repeat (LATENCY_SETTLE) @(negedge clk);

		s.gain_p = data_t'(UNIT);
		s.gain_i = data_t'(UNIT / 2);
		s.gain_d = data_t'(UNIT / 4);
		s.out_min = data_t'(-100 * UNIT);
		s.out_max = data_t'(100 * UNIT);
		s.thresh = mag_t'(50 * UNIT);
		s.limit = mag_t'(20 * UNIT);
		s.friction = mag_t'(2 * UNIT);
		apply_settings(s);
		@(posedge clk);
		// Setpoint just above one tenth: a zero drive goes to the negative floor,
		// a small positive one to the positive floor.
		load_word(CMD_SETPOINT, data_t'(6554));
		load_word(CMD_MEASURE, data_t'(6554));
		load_word(CMD_MEASURE, '0);
		// Setpoint just below one tenth clears the integral; no friction floor.
		load_word(CMD_SETPOINT, data_t'(6553));
		load_word(CMD_MEASURE, '0);
		load_word(CMD_SETPOINT, data_t'(-6554));
		load_word(CMD_MEASURE, data_t'(-6000));
		// Integral climbs to its limit and stays there.
		load_word(CMD_SETPOINT, data_t'(10 * UNIT));
		load_word(CMD_MEASURE, '0);
		load_word(CMD_MEASURE, '0);
		load_word(CMD_MEASURE, '0);
		// Errors beyond the threshold, positive and negative, clear the integral.
		load_word(CMD_MEASURE, data_t'(-60 * UNIT));
		load_word(CMD_MEASURE, data_t'(70 * UNIT));
		// Error saturation in both directions.
		load_word(CMD_SETPOINT, DATA_MAX);
		load_word(CMD_MEASURE, DATA_MIN);
		load_word(CMD_SETPOINT, DATA_MIN);
		load_word(CMD_MEASURE, DATA_MAX);
		load_word(CMD_MEASURE, DATA_MIN);
		load_word(CMD_SETPOINT, '0);
		load_word(CMD_MEASURE, data_t'(32'h5555_5555));
		load_word(CMD_MEASURE, data_t'(32'hAAAA_AAAA));
		wait_drained();
		repeat (LATENCY_SETTLE) @(negedge clk);

		// Extreme gains and limits, with the lower clamp above the upper one.
		s.gain_p = DATA_MAX;
		s.gain_i = DATA_MIN;
		s.gain_d = DATA_MAX;
		s.out_min = data_t'(5 * UNIT);
		s.out_max = data_t'(-5 * UNIT);
		s.thresh = MAG_MAX;
		s.limit = MAG_MAX;
		s.friction = MAG_MAX;
		apply_settings(s);
		@(posedge clk);
		load_word(CMD_SETPOINT, data_t'(3 * UNIT));
		load_word(CMD_MEASURE, '0);
		load_word(CMD_MEASURE, DATA_MIN);
		wait_drained();
		repeat (LATENCY_SETTLE) @(negedge clk);

		// Random phases; the sender pauses halfway until all drive words are back.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			apply_settings(pick_settings(phase_plan[p]));
			set_idling(idle_mode_t'(p % 4));
			repeat (2) begin
				@(posedge clk);
				repeat (WORDS_PER_PHASE / 2) begin
					word_t w;
					w = random_word();
					load_word(w.cmd, w.value);
				end
				wait_drained();
			end
			repeat (LATENCY_SETTLE) @(negedge clk);
		end

		set_idling(IDLE_NONE);
		wait_drained();
		repeat (LATENCY_SETTLE) @(negedge clk);
		if (mismatches == 0) begin
			$display("pid_anti_windup_friction_core verification clean");
		end else begin
			$display("pid_anti_windup_friction_core verification failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(RUN_LIMIT);
		$display("pid_anti_windup_friction_core verification failed");
		$finish;
	end

endmodule
